/* sv/sre_pkg.sv */
`default_nettype none
package sre_pkg;

    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 20;
    localparam int BIAS_W   = 24;
    localparam int CODE_W   = 16;

    localparam logic [CODE_W-1:0] CRC_INIT     = 16'hFFFF;
    localparam logic [CODE_W-1:0] CRC_POLY     = 16'h1021;
    localparam logic [CODE_W-1:0] MISSING_CODE = 16'hFFFF;

    localparam int DEF_SAMPLE_FRAC_BITS = 12;
    localparam int DEF_FIFO_DEPTH       = 16;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_value;
        logic [GAIN_W-1:0]   gain;
        logic [BIAS_W-1:0]   bias;
        logic [CODE_W-1:0]   digital_low;
        logic [CODE_W-1:0]   digital_high;
        logic                present;
        logic                valid_req;
        logic                end_of_record;
    } t_sample_req;

    typedef struct packed {
        logic [CODE_W-1:0] out_word;
        logic              word_is_crc;
        logic              record_done;
    } t_word_rsp;

    typedef struct packed {
        logic              vld;
        logic [CODE_W-1:0] word;
        logic              eor;
    } t_code;

    typedef struct packed {
        logic      vld;
        logic      two;
        t_word_rsp e0;
        t_word_rsp e1;
    } t_push;

    function automatic logic [CODE_W-1:0] crc_byte(input logic [CODE_W-1:0] crc,
                                                   input logic [7:0] b);
        logic [CODE_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[CODE_W-1]) begin
                c = {c[CODE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CODE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* sv/sre_if.sv */
`default_nettype none
interface sre_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/sre_scale.sv */
`default_nettype none
module sre_scale
    import sre_pkg::*;
#(
    parameter int SAMPLE_FRAC_BITS = DEF_SAMPLE_FRAC_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_vld,
    input  wire t_sample_req i_req,
    output t_code            o_code,
    output logic [2:0]       o_inflight
);

    localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
    localparam int BIAS_X_W = BIAS_W + SAMPLE_FRAC_BITS;
    localparam int SUM_W    = ((PROD_W > BIAS_X_W) ? PROD_W : BIAS_X_W) + 1;
    localparam int TOT      = SAMPLE_FRAC_BITS + 8;
    localparam int DW       = SUM_W - TOT;

    typedef struct packed {
        logic [CODE_W-1:0] dlo;
        logic [CODE_W-1:0] dhi;
        logic              ok;
        logic              eor;
    } t_side;

    logic                     r_s1_vld;
    t_sample_req              r_s1;
    logic                     r_s2_vld;
    logic signed [PROD_W-1:0] r_s2_prod;
    logic [BIAS_W-1:0]        r_s2_bias;
    t_side                    r_s2_side;
    logic                     r_s3_vld;
    logic signed [SUM_W-1:0]  r_s3_sum;
    t_side                    r_s3_side;
    logic                     r_s4_vld;
    logic [CODE_W-1:0]        r_s4_word;
    logic                     r_s4_eor;

    logic signed [PROD_W-1:0] n_prod;
    t_side                    n_side;
    logic signed [SUM_W-1:0]  w_prod_x;
    logic signed [SUM_W-1:0]  w_bias_x;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [SUM_W-1:0]  w_rnd;
    logic signed [DW-1:0]     w_d;
    logic signed [DW-1:0]     w_dlo_x;
    logic signed [DW-1:0]     w_dhi_x;
    logic [CODE_W-1:0]        n_word;

    assign n_prod = PROD_W'($signed(r_s1.sample_value))
                  * $signed(PROD_W'({1'b0, r_s1.gain}));
    assign n_side = '{dlo: r_s1.digital_low, dhi: r_s1.digital_high,
                      ok: r_s1.present & r_s1.valid_req, eor: r_s1.end_of_record};

    assign w_prod_x = {{(SUM_W-PROD_W){r_s2_prod[PROD_W-1]}}, r_s2_prod};
    assign w_bias_x = {{(SUM_W-BIAS_W){r_s2_bias[BIAS_W-1]}}, r_s2_bias} << SAMPLE_FRAC_BITS;
    assign n_sum    = w_prod_x + w_bias_x;

    // round half away from zero: add half, less one when negative, then floor
    assign w_rnd   = r_s3_sum + (SUM_W'(1) << (TOT - 1))
                     - {{(SUM_W-1){1'b0}}, r_s3_sum[SUM_W-1]};
    assign w_d     = w_rnd[SUM_W-1:TOT];
    assign w_dlo_x = {{(DW-CODE_W){r_s3_side.dlo[CODE_W-1]}}, r_s3_side.dlo};
    assign w_dhi_x = {{(DW-CODE_W){r_s3_side.dhi[CODE_W-1]}}, r_s3_side.dhi};

    always_comb begin
        priority if (!r_s3_side.ok) begin
            n_word = MISSING_CODE;
        end else if ($signed(r_s3_side.dhi) <= $signed(r_s3_side.dlo)) begin
            n_word = r_s3_side.dlo;
        end else if (w_d < w_dlo_x) begin
            n_word = r_s3_side.dlo;
        end else if (w_d > w_dhi_x) begin
            n_word = r_s3_side.dhi;
        end else begin
            n_word = w_d[CODE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_req_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1      <= i_req;
        r_s2_prod <= n_prod;
        r_s2_bias <= r_s1.bias;
        r_s2_side <= n_side;
        r_s3_sum  <= n_sum;
        r_s3_side <= r_s2_side;
        r_s4_word <= n_word;
        r_s4_eor  <= r_s3_side.eor;
    end

    assign o_code     = '{vld: r_s4_vld, word: r_s4_word, eor: r_s4_eor};
    assign o_inflight = {2'b00, r_s1_vld} + {2'b00, r_s2_vld}
                      + {2'b00, r_s3_vld} + {2'b00, r_s4_vld};

endmodule
`default_nettype wire

/* sv/sre_crc.sv */
`default_nettype none
module sre_crc
    import sre_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_code i_code,
    output t_push      o_push
);

    logic [CODE_W-1:0] r_crc;
    logic [CODE_W-1:0] w_crc_lo;
    logic [CODE_W-1:0] n_crc;

    assign w_crc_lo = crc_byte(r_crc, i_code.word[7:0]);
    assign n_crc    = crc_byte(w_crc_lo, i_code.word[15:8]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else if (i_code.vld) begin
            r_crc <= i_code.eor ? CRC_INIT : n_crc;
        end
    end

    assign o_push = '{vld: i_code.vld, two: i_code.eor,
                      e0: '{out_word: i_code.word, word_is_crc: 1'b0, record_done: 1'b0},
                      e1: '{out_word: n_crc, word_is_crc: 1'b1, record_done: 1'b1}};

endmodule
`default_nettype wire

/* sv/sre_fifo.sv */
`default_nettype none
module sre_fifo
    import sre_pkg::*;
#(
    parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_push                        i_push,
    sre_if.source                             o_wrd,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]   o_count
);

    localparam int IDX_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH+1);

    t_word_rsp        r_mem [FIFO_DEPTH];
    logic [IDX_W-1:0] r_wr;
    logic [IDX_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] w_wr1;
    logic [IDX_W-1:0] w_wr2;
    logic [CNT_W-1:0] w_push_n;
    logic             w_pop;

    function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(FIFO_DEPTH-1)) ? '0 : p + 1'b1;
    endfunction

    assign w_wr1    = nxt(r_wr);
    assign w_wr2    = nxt(w_wr1);
    assign w_pop    = o_wrd.valid && o_wrd.ready;
    assign w_push_n = !i_push.vld ? '0 : (i_push.two ? CNT_W'(2) : CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_mem[r_wr] <= i_push.e0;
            if (i_push.two) begin
                r_mem[w_wr1] <= i_push.e1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.vld) begin
                r_wr <= i_push.two ? w_wr2 : w_wr1;
            end
            if (w_pop) begin
                r_rd <= nxt(r_rd);
            end
            r_count <= r_count + w_push_n - {{(CNT_W-1){1'b0}}, w_pop};
        end
    end

    assign o_wrd.valid = (r_count != '0);
    assign o_wrd.data  = r_mem[r_rd];
    assign o_count     = r_count;

endmodule
`default_nettype wire

/* sv/sample_record_encoder_crc16.sv */
// A request passes stages s1 to s4 of sre_scale and the output queue to reach o_wrd.
// Throughput: one request per cycle while i_smp.ready holds; a request with end_of_record yields two
// words, so the output side then limits the rate to one word per cycle.
// i_smp.ready holds while output queue room for every request in flight is reserved.
// Reset: synchronous, active low; clears pipeline valids and queue, CRC to 0xFFFF.
`default_nettype none
module sample_record_encoder_crc16
    import sre_pkg::*;
#(
    parameter int SAMPLE_FRAC_BITS = DEF_SAMPLE_FRAC_BITS,
    parameter int FIFO_DEPTH       = DEF_FIFO_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sre_if.sink       i_smp,
    sre_if.source     o_wrd
);

    localparam int CNT_W = $clog2(FIFO_DEPTH+1);
    localparam int RSV_W = CNT_W + 4;

    t_code            w_code;
    t_push            w_push;
    logic [2:0]       w_inflight;
    logic [CNT_W-1:0] w_count;
    logic [RSV_W-1:0] w_reserve;
    logic             w_accept;

    assign w_reserve   = RSV_W'(w_count) + RSV_W'({w_inflight, 1'b0}) + RSV_W'(2);
    assign i_smp.ready = (w_reserve <= RSV_W'(FIFO_DEPTH));
    assign w_accept    = i_smp.valid && i_smp.ready;

    sre_scale #(
        .SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS)
    ) u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_vld  (w_accept),
        .i_req      (i_smp.data),
        .o_code     (w_code),
        .o_inflight (w_inflight)
    );

    sre_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_code  (w_code),
        .o_push  (w_push)
    );

    sre_fifo #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_wrd   (o_wrd),
        .o_count (w_count)
    );

    a_room_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (RSV_W'(w_count) + RSV_W'({w_inflight, 1'b0})) <= RSV_W'(FIFO_DEPTH))
        else $error("output queue reservation exceeded");

    a_crc_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wrd.valid |-> (o_wrd.data.word_is_crc == o_wrd.data.record_done))
        else $error("crc word and record end flags disagree");

    a_push_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.vld && w_push.two) |=> (w_count >= CNT_W'(2)))
        else $error("two-word push not reflected in queue count");

endmodule
`default_nettype wire

/* verif/sample_record_encoder_crc16_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module sample_record_encoder_crc16_tb;
    import sre_pkg::*;

    localparam int FRAC_BITS = DEF_SAMPLE_FRAC_BITS;
    localparam int RANDOM_ITEMS = 550;
    localparam int CALM_FROM = 250;
    localparam int CALM_TO = 350;
    localparam int DRAIN_AT = 400;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sre_if #(.t_payload(t_sample_req)) smp_if ();
    sre_if #(.t_payload(t_word_rsp))   wrd_if ();

    sample_record_encoder_crc16 #(
        .SAMPLE_FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_smp  (smp_if),
        .o_wrd  (wrd_if)
    );

    t_sample_req       pending_samples[$];
    t_word_rsp         expected_words[$];
    logic [CODE_W-1:0] record_crc;
    logic              smp_taken;
    int                sent_cnt;
    int                total_items;
    int                directed_cnt;
    int                err_cnt;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [CODE_W-1:0] sample_code(input t_sample_req r);
        longint lo, hi, smp, gn, bs, acc, mag, q, d;
        if (!(r.present && r.valid_req)) begin
            return MISSING_CODE;
        end
        lo = longint'($signed(r.digital_low));
        hi = longint'($signed(r.digital_high));
        if (hi <= lo) begin
            return r.digital_low;
        end
        smp = longint'($signed(r.sample_value));
        gn = longint'({1'b0, r.gain});
        bs = longint'($signed(r.bias));
        acc = smp * gn + bs * (longint'(1) << FRAC_BITS);
        mag = (acc < 0) ? -acc : acc;
        q = (mag + (longint'(1) << (FRAC_BITS + 7))) >>> (FRAC_BITS + 8);
        d = (acc < 0) ? -q : q;
        if (d < lo) begin
            d = lo;
        end
        if (d > hi) begin
            d = hi;
        end
        return d[CODE_W-1:0];
    endfunction

    // low byte first, MSB first within each byte
    function automatic logic [CODE_W-1:0] crc_after_word(input logic [CODE_W-1:0] crc,
                                                         input logic [CODE_W-1:0] w);
        logic [CODE_W-1:0] c;
        logic [7:0]        b;
        c = crc;
        for (int k = 0; k < 2; k++) begin
            b = (k == 0) ? w[7:0] : w[15:8];
            c = c ^ {b, 8'h00};
            for (int n = 0; n < 8; n++) begin
                c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic void queue_sample(input logic [SAMPLE_W-1:0] s,
                                         input logic [GAIN_W-1:0] g,
                                         input logic [BIAS_W-1:0] b,
                                         input logic [CODE_W-1:0] lo,
                                         input logic [CODE_W-1:0] hi,
                                         input logic p, input logic v, input logic e);
        t_sample_req r;
        r.sample_value = s;
        r.gain = g;
        r.bias = b;
        r.digital_low = lo;
        r.digital_high = hi;
        r.present = p;
        r.valid_req = v;
        r.end_of_record = e;
        pending_samples.push_back(r);
    endfunction

    function automatic t_sample_req random_sample();
        t_sample_req       r;
        logic [CODE_W-1:0] a, c;
        r.sample_value = SAMPLE_W'($urandom);
        if ($urandom_range(9) < 4) begin
            r.gain = GAIN_W'($urandom);
            r.bias = BIAS_W'($urandom);
        end else begin
            r.gain = GAIN_W'($urandom_range(1023));
            r.bias = BIAS_W'($urandom_range(1 << 20) - (1 << 19));
            if ($urandom_range(1)) begin
                r.sample_value = SAMPLE_W'($urandom_range(1 << 18) - (1 << 17));
            end
        end
        a = CODE_W'($urandom);
        c = CODE_W'($urandom);
        case ($urandom_range(9))
            0: begin
                r.digital_low = a;
                r.digital_high = $urandom_range(1) ? a
                                 : a - CODE_W'($urandom_range(99) + 1);
                if ($signed(r.digital_high) > $signed(r.digital_low)) begin
                    r.digital_high = r.digital_low;
                end
            end
            1: begin
                r.digital_low = 16'h8000;
                r.digital_high = 16'h7FFF;
            end
            default: begin
                r.digital_low = ($signed(a) < $signed(c)) ? a : c;
                r.digital_high = ($signed(a) < $signed(c)) ? c : a;
            end
        endcase
        r.present = $urandom_range(15) != 0;
        r.valid_req = $urandom_range(15) != 0;
        r.end_of_record = $urandom_range(7) == 0;
        return r;
    endfunction

    task automatic report(input string what, input int got, input int want);
        err_cnt++;
        $display("%0t ns: %s mismatch, got %0h want %0h", $realtime, what, got, want);
    endtask

    always @(negedge i_clk) begin : drive_req
        if (!i_rst_n) begin
            smp_if.valid <= 1'b0;
        end else if (smp_if.valid && !smp_taken) begin
            // hold the request until it is taken
        end else if (pending_samples.size() == 0
                     || ((sent_cnt == directed_cnt || sent_cnt == DRAIN_AT)
                         && expected_words.size() != 0)
                     || (!(sent_cnt >= CALM_FROM && sent_cnt < CALM_TO)
                         && $urandom_range(99) < 14)) begin
            smp_if.valid <= 1'b0;
        end else begin
            smp_if.valid <= 1'b1;
            smp_if.data <= pending_samples.pop_front();
        end
    end

    always @(negedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            wrd_if.ready <= 1'b0;
        end else begin
            wrd_if.ready <= (sent_cnt >= CALM_FROM && sent_cnt < CALM_TO)
                            || $urandom_range(99) >= 14;
        end
    end

    always @(posedge i_clk) begin : watch
        t_word_rsp         got, want;
        logic [CODE_W-1:0] code;
        if (!i_rst_n) begin
            smp_taken <= 1'b0;
            record_crc = CRC_INIT;
        end else begin
            smp_taken <= smp_if.valid && smp_if.ready;
            if (wrd_if.valid && wrd_if.ready) begin
                got = wrd_if.data;
                if (expected_words.size() == 0) begin
                    report("unexpected word", got.out_word, 0);
                end else begin
                    want = expected_words.pop_front();
                    if (got.out_word !== want.out_word) begin
                        report("out_word", got.out_word, want.out_word);
                    end
                    if (got.word_is_crc !== want.word_is_crc) begin
                        report("word_is_crc", got.word_is_crc, want.word_is_crc);
                    end
                    if (got.record_done !== want.record_done) begin
                        report("record_done", got.record_done, want.record_done);
                    end
                end
            end
            if (smp_if.valid && smp_if.ready) begin
                code = sample_code(smp_if.data);
                record_crc = crc_after_word(record_crc, code);
                expected_words.push_back('{out_word: code, word_is_crc: 1'b0,
                                           record_done: 1'b0});
                if (smp_if.data.end_of_record) begin
                    expected_words.push_back('{out_word: record_crc, word_is_crc: 1'b1,
                                               record_done: 1'b1});
                    record_crc = CRC_INIT;
                end
                sent_cnt++;
            end
        end
    end

    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        smp_if.valid = 1'b0;
        smp_if.data = '0;
        wrd_if.ready = 1'b0;
        sent_cnt = 0;
        err_cnt = 0;

        queue_sample(0, 0, 0, 16'h8000, 16'h7FFF, 1, 1, 0);
        queue_sample(24'h7FFFFF, 20'hFFFFF, 24'h7FFFFF, 16'h8000, 16'h7FFF, 1, 1, 0);
        queue_sample(24'h800000, 20'hFFFFF, 24'h800000, 16'h8000, 16'h7FFF, 1, 1, 0);
        queue_sample(24'h000800, 20'h00100, 0, 16'h8000, 16'h7FFF, 1, 1, 0);
        queue_sample(24'hFFF800, 20'h00100, 0, 16'h8000, 16'h7FFF, 1, 1, 0);
        queue_sample(24'hFFE800, 20'h00100, 0, 16'h8000, 16'h7FFF, 1, 1, 0);
        queue_sample(24'h001000, 20'h00100, 24'h000080, 16'h8000, 16'h7FFF, 1, 1, 1);
        queue_sample(24'h123456, 20'h00100, 0, 16'd100, 16'd100, 1, 1, 0);
        queue_sample(24'h123456, 20'h00100, 0, 16'd500, -16'sd500, 1, 1, 0);
        queue_sample(24'h001000, 20'h00100, 0, 16'h8000, 16'h7FFF, 0, 1, 1);
        queue_sample(24'h001000, 20'h00100, 0, 16'h8000, 16'h7FFF, 1, 0, 0);
        queue_sample(24'h001000, 20'h00100, 0, 16'd7, 16'd3, 0, 0, 0);
        queue_sample(24'h7FFFFF, 0, 24'hFFF380, 16'h8000, 16'h7FFF, 1, 1, 0);
        queue_sample(24'h005000, 20'h00100, 0, 16'd0, 16'd1, 1, 1, 1);
        queue_sample(24'h7FFFFF, 20'h00001, 0, 16'h8000, 16'h7FFF, 1, 1, 1);
        queue_sample(24'h800000, 20'h00001, 0, 16'h8000, 16'h8001, 1, 1, 0);
        queue_sample(0, 0, 0, 16'd10, 16'd20, 1, 1, 0);
        queue_sample(24'hFFFFFF, 20'h80000, 24'h7FFF00, 16'h7FFE, 16'h7FFF, 1, 1, 0);
        queue_sample(24'h400000, 20'h00200, 24'h800000, 16'h8000, 16'h7FFF, 1, 1, 1);
        directed_cnt = pending_samples.size();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pending_samples.push_back(random_sample());
        end
        total_items = pending_samples.size();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (sent_cnt < total_items) @(negedge i_clk);
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
